### hw/rtl/lex_pkg.sv
// Shared types, character constants and classification helpers for the lexer.
// No dependencies; the scanner, queue and top-level RTL files import this package.
package lex_pkg;

   localparam int MAX_TOKEN_CHARS_DEFAULT = 63;
   localparam int POSITION_BITS_DEFAULT   = 16;

   // Result queue: power of two, at least two entries
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_HASH       = 8'h23;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_EQUALS     = 8'h3D;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_LPAREN     = 8'h28;
   localparam logic [7:0] CHAR_RPAREN     = 8'h29;
   localparam logic [7:0] CHAR_LBRACE     = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE     = 8'h7D;

   // Keyword "int", one character per match step
   localparam logic [2:0][7:0] KEYWORD_TEXT = {8'h74, 8'h6E, 8'h69};
   localparam logic [2:0] KW_FULL     = 3'd3;
   localparam logic [2:0] KW_MISMATCH = 3'd4;

   typedef enum logic [3:0] {
      KIND_INT    = 4'd0,
      KIND_IDENT  = 4'd1,
      KIND_ASSIGN = 4'd2,
      KIND_NUMBER = 4'd3,
      KIND_PLUS   = 4'd4,
      KIND_MINUS  = 4'd5,
      KIND_LPAREN = 4'd6,
      KIND_RPAREN = 4'd7,
      KIND_LBRACE = 4'd8,
      KIND_RBRACE = 4'd9,
      KIND_EOF    = 4'd10,
      KIND_ERROR  = 4'd11
   } token_kind_type;

   typedef struct packed {
      logic [7:0] source_byte;
   } req_word_type;

   typedef struct packed {
      token_kind_type token_kind;
      logic [15:0]    token_start;
      logic [5:0]     token_length;
      logic           length_truncated;
      logic [7:0]     bad_byte;
      logic           last_of_run;
   } rsp_word_type;

   // Up to two tokens produced by one source byte, in order
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } token_push_type;

   typedef struct packed {
      logic [QUEUE_PTR_BITS:0] count;
      logic                    has_room;
   } queue_status_type;

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
   endfunction

   function automatic token_kind_type symbol_kind(input logic [7:0] b);
      token_kind_type k;
      case (b)
         CHAR_EQUALS: k = KIND_ASSIGN;
         CHAR_PLUS:   k = KIND_PLUS;
         CHAR_MINUS:  k = KIND_MINUS;
         CHAR_LPAREN: k = KIND_LPAREN;
         CHAR_RPAREN: k = KIND_RPAREN;
         CHAR_LBRACE: k = KIND_LBRACE;
         CHAR_RBRACE: k = KIND_RBRACE;
         default:     k = KIND_ERROR;
      endcase
      return k;
   endfunction

endpackage

### hw/rtl/lex_chan_if.sv
// Valid/ready channel carrying one payload word per handshake.
// Payload type is a parameter; the lexer uses lex_pkg word types.
interface lex_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/lex_scanner.sv
// Scanner state and single-pass next-state/token logic for one source byte.
// Depends on lex_pkg.
module lex_scanner #(
   parameter int MAX_TOKEN_CHARS = 63,
   parameter int POSITION_BITS   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              source_byte,
   output lex_pkg::token_push_type push,
   output logic                    halted
);
   import lex_pkg::*;

   localparam int RUN_BITS = $clog2(MAX_TOKEN_CHARS + 1);
   localparam logic [RUN_BITS-1:0] RUN_MAX = RUN_BITS'(MAX_TOKEN_CHARS);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_COMMENT,
      MODE_HALTED
   } mode_type;

   mode_type                 mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [RUN_BITS-1:0]      run_ff, run_in;
   logic                     ovf_ff, ovf_in;
   logic [2:0]               kw_ff, kw_in;

   logic                b_alpha, b_digit, b_space, b_symbol;
   logic                continue_run, fresh, start_run, close_tok, idle_tok;
   logic [RUN_BITS-1:0] base_run;
   logic                base_ovf;
   logic [2:0]          base_kw;
   logic [31:0]         start_wide, pos_wide;
   logic [7:0]          run_wide;
   rsp_word_type        close_word, idle_word;
   token_kind_type      idle_kind;

   always_comb begin
      b_alpha  = is_alpha(source_byte);
      b_digit  = is_digit(source_byte);
      b_space  = is_space(source_byte);
      b_symbol = symbol_kind(source_byte) != KIND_ERROR;

      continue_run = (mode_ff == MODE_IDENT &&
                      (b_alpha || b_digit || source_byte == CHAR_UNDERSCORE)) ||
                     (mode_ff == MODE_NUMBER && b_digit);
      // Byte is handled as in idle mode (possibly after closing a token)
      fresh = mode_ff == MODE_IDLE ||
              ((mode_ff == MODE_IDENT || mode_ff == MODE_NUMBER) && !continue_run) ||
              (mode_ff == MODE_COMMENT &&
               (source_byte == CHAR_NEWLINE || source_byte == CHAR_NUL));
      start_run = fresh && (b_alpha || b_digit);

      close_tok = (mode_ff == MODE_IDENT || mode_ff == MODE_NUMBER) && !continue_run;
      idle_tok  = fresh && (source_byte == CHAR_NUL ||
                  !(b_space || b_alpha || b_digit || source_byte == CHAR_HASH));

      base_run = start_run ? '0 : run_ff;
      base_ovf = start_run ? 1'b0 : ovf_ff;
      base_kw  = start_run ? 3'd0 : kw_ff;

      mode_in  = mode_ff;
      pos_in   = pos_ff;
      start_in = start_run ? pos_ff : start_ff;
      run_in   = run_ff;
      ovf_in   = ovf_ff;
      kw_in    = kw_ff;

      if (continue_run || start_run) begin
         if (base_run < RUN_MAX) begin
            run_in = base_run + RUN_BITS'(1);
            ovf_in = base_ovf;
         end else begin
            run_in = base_run;
            ovf_in = 1'b1;
         end
         if (base_kw < KW_FULL && source_byte == KEYWORD_TEXT[base_kw[1:0]]) begin
            kw_in = base_kw + 3'd1;
         end else begin
            kw_in = KW_MISMATCH;
         end
      end

      if (fresh) begin
         if (source_byte == CHAR_NUL || b_space || b_symbol) begin
            mode_in = MODE_IDLE;
         end else if (b_alpha) begin
            mode_in = MODE_IDENT;
         end else if (b_digit) begin
            mode_in = MODE_NUMBER;
         end else if (source_byte == CHAR_HASH) begin
            mode_in = MODE_COMMENT;
         end else begin
            mode_in = MODE_HALTED;
         end
      end

      if (mode_ff != MODE_HALTED) begin
         pos_in = (fresh && source_byte == CHAR_NUL) ? '0 :
                  pos_ff + POSITION_BITS'(1);
      end

      start_wide = 32'(start_ff);
      pos_wide   = 32'(pos_ff);
      run_wide   = 8'(run_ff);

      close_word.token_kind       = (mode_ff == MODE_NUMBER) ? KIND_NUMBER :
                                    (kw_ff == KW_FULL) ? KIND_INT : KIND_IDENT;
      close_word.token_start      = start_wide[15:0];
      close_word.token_length     = run_wide[5:0];
      close_word.length_truncated = ovf_ff;
      close_word.bad_byte         = '0;
      close_word.last_of_run      = !idle_tok;

      idle_kind = (source_byte == CHAR_NUL) ? KIND_EOF : symbol_kind(source_byte);
      idle_word.token_kind       = idle_kind;
      idle_word.token_start      = pos_wide[15:0];
      idle_word.token_length     = (source_byte == CHAR_NUL) ? 6'd0 : 6'd1;
      idle_word.length_truncated = 1'b0;
      idle_word.bad_byte         = (idle_kind == KIND_ERROR) ? source_byte : 8'd0;
      idle_word.last_of_run      = 1'b1;

      push.second = idle_word;
      if (close_tok) begin
         push.first = close_word;
      end else begin
         push.first = idle_word;
      end
      if (!accept || mode_ff == MODE_HALTED) begin
         push.count = 2'd0;
      end else begin
         push.count = 2'(close_tok) + 2'(idle_tok);
      end

      halted = mode_ff == MODE_HALTED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         run_ff   <= '0;
         ovf_ff   <= 1'b0;
         kw_ff    <= 3'd0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         run_ff   <= run_in;
         ovf_ff   <= ovf_in;
         kw_ff    <= kw_in;
      end
   end

endmodule

### hw/rtl/lex_token_queue.sv
// Small result queue: takes up to two tokens per cycle, delivers at most one.
// Depends on lex_pkg.
module lex_token_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  lex_pkg::token_push_type   push,
   input  logic                      pop,
   output lex_pkg::rsp_word_type     head_word,
   output lex_pkg::queue_status_type status
);
   import lex_pkg::*;

   rsp_word_type entries_ff [QUEUE_DEPTH];

   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic [QUEUE_PTR_BITS-1:0] wr_next;

   always_comb begin
      wr_next   = wr_ptr_ff + QUEUE_PTR_BITS'(1);
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
      count_in  = count_ff + (QUEUE_PTR_BITS + 1)'(push.count) -
                  (QUEUE_PTR_BITS + 1)'(pop);

      head_word       = entries_ff[rd_ptr_ff];
      status.count    = count_ff;
      // Room for a byte that closes a token and emits a second one
      status.has_room = count_ff <= (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH - 2);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/small_language_lexer_top.sv
// Lexer top level: scanner state machine feeding a four-word result queue.
// A token is written into the result queue by the byte that completes it, then offered on rsp_if.
// Throughput: one source byte per cycle; a byte emits up to two tokens, and the single-word
//   result port drains at most one per cycle, so req_if.ready drops while the queue holds three or more.
// Reset (synchronous, active high): idle mode, position zero, queue empty.
// Depends on lex_pkg, lex_chan_if, lex_scanner, lex_token_queue.
module small_language_lexer_top #(
   parameter int MAX_TOKEN_CHARS = lex_pkg::MAX_TOKEN_CHARS_DEFAULT,
   parameter int POSITION_BITS   = lex_pkg::POSITION_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   lex_chan_if.sink   req_if,
   lex_chan_if.source rsp_if
);
   import lex_pkg::*;

   req_word_type     req_word;
   rsp_word_type     head_word;
   token_push_type   push;
   queue_status_type queue_status;
   logic             req_accept, rsp_accept, halted;

   assign req_word     = req_if.data;
   assign req_if.ready = queue_status.has_room;
   assign req_accept   = req_if.valid && queue_status.has_room;

   assign rsp_if.valid = queue_status.count != '0;
   assign rsp_if.data  = head_word;
   assign rsp_accept   = rsp_if.valid && rsp_if.ready;

   lex_scanner #(
      .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS),
      .POSITION_BITS  (POSITION_BITS)
   ) u_scanner (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .source_byte(req_word.source_byte),
      .push       (push),
      .halted     (halted)
   );

   lex_token_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (rsp_accept),
      .head_word(head_word),
      .status   (queue_status)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_status.count <= (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH))
      else $error("result queue over capacity");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted |=> halted)
      else $error("halt released without reset");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      halted |-> push.count == 2'd0)
      else $error("token emitted while halted");

   a_pair_closes_run: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> (push.first.token_kind == KIND_INT ||
                              push.first.token_kind == KIND_IDENT ||
                              push.first.token_kind == KIND_NUMBER))
      else $error("two tokens from one byte without a closed run");

endmodule

### tb/small_language_lexer_top_tb.sv
// Self-checking testbench for small_language_lexer_top: drives source bytes, predicts tokens.
// Depends on lex_pkg, lex_chan_if and the lexer RTL; needs no files or arguments at run time.
module small_language_lexer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lex_pkg::*;

   localparam int MAX_CHARS   = 63;
   localparam int CYCLE_LIMIT = 600000;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_IDENT,
      SCAN_NUMBER,
      SCAN_COMMENT,
      SCAN_HALTED
   } scan_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lex_chan_if #(.payload_type(req_word_type)) req_chan ();
   lex_chan_if #(.payload_type(rsp_word_type)) rsp_chan ();

   small_language_lexer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   always #2 clock = ~clock;

   // Predicted lexer state
   scan_mode_type scan_state   = SCAN_IDLE;
   logic [15:0]   cur_position = '0;
   logic [15:0]   run_start    = '0;
   logic [5:0]    run_len      = '0;
   logic          run_overflow = 1'b0;
   logic [2:0]    kw_matched   = '0;

   rsp_word_type pending_tokens [$];

   int  error_count  = 0;
   int  bytes_sent   = 0;
   int  cycle_count  = 0;
   bit  sender_idle  = 1'b0;
   bit  receiver_stall = 1'b0;

   function automatic logic char_is_letter(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic char_is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic char_is_blank(input logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic token_kind_type symbol_token(input logic [7:0] b);
      case (b)
         CHAR_EQUALS: return KIND_ASSIGN;
         CHAR_PLUS:   return KIND_PLUS;
         CHAR_MINUS:  return KIND_MINUS;
         CHAR_LPAREN: return KIND_LPAREN;
         CHAR_RPAREN: return KIND_RPAREN;
         CHAR_LBRACE: return KIND_LBRACE;
         CHAR_RBRACE: return KIND_RBRACE;
         default:     return KIND_ERROR;
      endcase
   endfunction

   function automatic rsp_word_type make_token(input token_kind_type kind,
                                               input logic [15:0] start,
                                               input logic [5:0] len,
                                               input logic trunc,
                                               input logic [7:0] bad);
      rsp_word_type t;
      t.token_kind       = kind;
      t.token_start      = start;
      t.token_length     = len;
      t.length_truncated = trunc;
      t.bad_byte         = bad;
      t.last_of_run      = 1'b0;
      return t;
   endfunction

   function automatic void start_run(input scan_mode_type mode);
      scan_state   = mode;
      run_start    = cur_position;
      run_len      = '0;
      run_overflow = 1'b0;
      kw_matched   = '0;
   endfunction

   function automatic void extend_run(input logic [7:0] b);
      if (run_len < 6'(MAX_CHARS))
         run_len = run_len + 6'd1;
      else
         run_overflow = 1'b1;
      if (kw_matched < KW_FULL && b == KEYWORD_TEXT[kw_matched])
         kw_matched = kw_matched + 3'd1;
      else
         kw_matched = KW_MISMATCH;
   endfunction

   // Advance the predicted state by one accepted byte and queue its tokens
   function automatic void predict_tokens(input logic [7:0] b);
      rsp_word_type made [2];
      int n;
      n = 0;
      if (scan_state == SCAN_HALTED)
         return;
      case (scan_state)
         SCAN_IDENT: begin
            if (char_is_letter(b) || char_is_digit(b) || b == CHAR_UNDERSCORE) begin
               extend_run(b);
               cur_position = cur_position + 16'd1;
               return;
            end
            made[n] = make_token(kw_matched == KW_FULL ? KIND_INT : KIND_IDENT,
                                 run_start, run_len, run_overflow, 8'h00);
            n++;
            scan_state = SCAN_IDLE;
         end
         SCAN_NUMBER: begin
            if (char_is_digit(b)) begin
               extend_run(b);
               cur_position = cur_position + 16'd1;
               return;
            end
            made[n] = make_token(KIND_NUMBER, run_start, run_len, run_overflow, 8'h00);
            n++;
            scan_state = SCAN_IDLE;
         end
         SCAN_COMMENT: begin
            if (b != CHAR_NEWLINE && b != CHAR_NUL) begin
               cur_position = cur_position + 16'd1;
               return;
            end
            scan_state = SCAN_IDLE;
         end
         default: ;
      endcase

      // The closing byte is then handled as in idle mode
      if (b == CHAR_NUL) begin
         made[n] = make_token(KIND_EOF, cur_position, 6'd0, 1'b0, 8'h00);
         n++;
      end else if (char_is_blank(b)) begin
      end else if (char_is_letter(b)) begin
         start_run(SCAN_IDENT);
         extend_run(b);
      end else if (char_is_digit(b)) begin
         start_run(SCAN_NUMBER);
         extend_run(b);
      end else if (b == CHAR_HASH) begin
         scan_state = SCAN_COMMENT;
      end else if (symbol_token(b) != KIND_ERROR) begin
         made[n] = make_token(symbol_token(b), cur_position, 6'd1, 1'b0, 8'h00);
         n++;
      end else begin
         made[n] = make_token(KIND_ERROR, cur_position, 6'd1, 1'b0, b);
         n++;
         scan_state = SCAN_HALTED;
      end

      cur_position = (b == CHAR_NUL) ? 16'h0000 : cur_position + 16'd1;

      for (int i = 0; i < n; i++) begin
         made[i].last_of_run = (i == n - 1);
         pending_tokens.push_back(made[i]);
      end
   endfunction

   // True when this byte would stop the lexer in its present state
   function automatic logic would_halt(input logic [7:0] b);
      case (scan_state)
         SCAN_IDENT:
            if (char_is_letter(b) || char_is_digit(b) || b == CHAR_UNDERSCORE) return 1'b0;
         SCAN_NUMBER:
            if (char_is_digit(b)) return 1'b0;
         SCAN_COMMENT:
            if (b != CHAR_NUL && b != CHAR_NEWLINE) return 1'b0;
         default: ;
      endcase
      return !(b == CHAR_NUL || char_is_blank(b) || char_is_letter(b) || char_is_digit(b)
               || b == CHAR_HASH || symbol_token(b) != KIND_ERROR);
   endfunction

   // Entered and left at a falling edge; valid stays high for the next word
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (sender_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data.source_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      predict_tokens(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   // Replace a byte that would halt the lexer with a blank
   task automatic send_safe(input logic [7:0] b);
      send_byte(would_halt(b) ? CHAR_SPACE : b);
   endtask

   function automatic logic [7:0] random_letter();
      int r;
      r = $urandom_range(0, 51);
      return (r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26);
   endfunction

   function automatic logic [7:0] random_ident_char();
      int r;
      r = $urandom_range(0, 62);
      if (r < 52) return random_letter();
      if (r < 62) return 8'(8'h30 + r - 52);
      return CHAR_UNDERSCORE;
   endfunction

   function automatic logic [7:0] random_comment_char();
      logic [7:0] c;
      c = 8'($urandom_range(1, 255));
      return (c == CHAR_NEWLINE) ? CHAR_TAB : c;
   endfunction

   function automatic int random_run_length();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
   endfunction

   task automatic send_identifier();
      int len;
      case ($urandom_range(0, 11))
         0: send_text("int");
         1: send_text("in");
         2: send_text("intx");
         3: send_text("int_7");
         4: send_text("i");
         5: send_text("Int");
         default: begin
            len = random_run_length();
            send_safe(random_letter());
            for (int i = 1; i < len; i++)
               send_safe(random_ident_char());
         end
      endcase
   endtask

   task automatic send_number();
      int len;
      len = random_run_length();
      for (int i = 0; i < len; i++)
         send_safe(8'(8'h30 + $urandom_range(0, 9)));
   endtask

   task automatic send_symbol();
      case ($urandom_range(0, 6))
         0: send_safe(CHAR_EQUALS);
         1: send_safe(CHAR_PLUS);
         2: send_safe(CHAR_MINUS);
         3: send_safe(CHAR_LPAREN);
         4: send_safe(CHAR_RPAREN);
         5: send_safe(CHAR_LBRACE);
         default: send_safe(CHAR_RBRACE);
      endcase
   endtask

   task automatic send_blanks();
      int len;
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++)
         send_safe(($urandom_range(0, 5) == 0) ? CHAR_SPACE : 8'($urandom_range(9, 13)));
   endtask

   task automatic send_comment();
      int len;
      len = $urandom_range(0, 8);
      send_safe(CHAR_HASH);
      for (int i = 0; i < len; i++)
         send_safe(random_comment_char());
      send_safe(($urandom_range(0, 5) == 0) ? CHAR_NUL : CHAR_NEWLINE);
   endtask

   task automatic send_noise();
      logic [7:0] c;
      int len;
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
         do c = 8'($urandom_range(0, 255)); while (would_halt(c));
         send_byte(c);
      end
   endtask

   // Directed: every token kind but the error token, keyword prefixes, closing bytes that add a second token
   task automatic test_token_kinds();
      sender_idle    = 1'b1;
      receiver_stall = 1'b1;
      send_text("int x_9(0){in}\t=+-a");
      send_byte(CHAR_NUL);
   endtask

   // Directed: newline ends a comment, high bytes inside it, end of input inside it
   task automatic test_comments();
      send_byte(CHAR_HASH);
      send_byte("z");
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(CHAR_NEWLINE);
      send_text("5#q");
      send_byte(CHAR_NUL);
   endtask

   task automatic test_random_program(input int count, input bit with_idle);
      int target;
      sender_idle    = with_idle;
      receiver_stall = with_idle;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         case ($urandom_range(0, 99)) inside
            [0:29]:  send_identifier();
            [30:44]: send_number();
            [45:64]: send_symbol();
            [65:79]: send_blanks();
            [80:87]: send_comment();
            [88:91]: send_safe(CHAR_NUL);
            default: send_noise();
         endcase
      end
   endtask

   // Underscore after a number: number token, then the error token; later bytes are dropped
   task automatic test_error_halt();
      sender_idle    = 1'b0;
      receiver_stall = 1'b0;
      send_byte(CHAR_NUL);
      send_text("7_");
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(CHAR_NUL);
      send_byte(CHAR_NEWLINE);
      for (int i = 0; i < 16; i++)
         send_byte(8'($urandom_range(0, 255)));
   endtask

   // Result side: random stall bursts while enabled
   initial begin
      int burst;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (receiver_stall && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 14);
            rsp_chan.ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_tokens
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.data;
         if (pending_tokens.size() == 0) begin
            $error("unexpected token: kind %0d start %0d", got.token_kind, got.token_start);
            error_count++;
         end else begin
            want = pending_tokens.pop_front();
            if (got.token_kind !== want.token_kind) begin
               $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
               error_count++;
            end
            if (got.token_start !== want.token_start) begin
               $error("token_start: expected %0d, got %0d", want.token_start, got.token_start);
               error_count++;
            end
            if (got.token_length !== want.token_length) begin
               $error("token_length: expected %0d, got %0d", want.token_length,
                      got.token_length);
               error_count++;
            end
            if (got.length_truncated !== want.length_truncated) begin
               $error("length_truncated: expected %0d, got %0d", want.length_truncated,
                      got.length_truncated);
               error_count++;
            end
            if (got.bad_byte !== want.bad_byte) begin
               $error("bad_byte: expected %0h, got %0h", want.bad_byte, got.bad_byte);
               error_count++;
            end
            if (got.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_token_kinds();
      test_comments();
      test_random_program(220, 1'b1);
      test_random_program(180, 1'b1);
      test_random_program(100, 1'b0);
      test_error_halt();

      // Drop valid after the last word, then drain
      req_chan.valid <= 1'b0;
      while (pending_tokens.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
